// ===== rtl/gsc_pkg.sv =====
// ----------------------------------------------------------------------------
// gsc_pkg: shared types and codes for the GPIO set/clear register block
// Item and result types, operation codes and register word offsets.
// ----------------------------------------------------------------------------
package gsc_pkg;

    typedef logic [1:0]  t_opcode;
    typedef logic [5:0]  t_reg_idx;
    typedef logic [31:0] t_word;

    localparam t_opcode OP_READ   = 2'd0;
    localparam t_opcode OP_WRITE  = 2'd1;
    localparam t_opcode OP_SAMPLE = 2'd2;

    // register word offsets (byte offset / 4)
    localparam t_reg_idx REG_PER  = 6'd0;
    localparam t_reg_idx REG_PDR  = 6'd1;
    localparam t_reg_idx REG_PSR  = 6'd2;
    localparam t_reg_idx REG_OER  = 6'd4;
    localparam t_reg_idx REG_ODR  = 6'd5;
    localparam t_reg_idx REG_OSR  = 6'd6;
    localparam t_reg_idx REG_IFER = 6'd8;
    localparam t_reg_idx REG_IFDR = 6'd9;
    localparam t_reg_idx REG_IFSR = 6'd10;
    localparam t_reg_idx REG_SODR = 6'd12;
    localparam t_reg_idx REG_CODR = 6'd13;
    localparam t_reg_idx REG_ODSR = 6'd14;
    localparam t_reg_idx REG_PDSR = 6'd15;
    localparam t_reg_idx REG_IER  = 6'd16;
    localparam t_reg_idx REG_IDR  = 6'd17;
    localparam t_reg_idx REG_IMR  = 6'd18;
    localparam t_reg_idx REG_ISR  = 6'd19;
    localparam t_reg_idx REG_MDER = 6'd20;
    localparam t_reg_idx REG_MDDR = 6'd21;
    localparam t_reg_idx REG_MDSR = 6'd22;
    localparam t_reg_idx REG_PUDR = 6'd24;
    localparam t_reg_idx REG_PUER = 6'd25;
    localparam t_reg_idx REG_PUSR = 6'd26;
    localparam t_reg_idx REG_ASR  = 6'd28;
    localparam t_reg_idx REG_BSR  = 6'd29;
    localparam t_reg_idx REG_ABSR = 6'd30;
    localparam t_reg_idx REG_OWER = 6'd40;
    localparam t_reg_idx REG_OWDR = 6'd41;
    localparam t_reg_idx REG_OWSR = 6'd42;

    // one item handed to the register bank
    typedef struct packed {
        logic     valid;
        t_opcode  opcode;
        t_reg_idx reg_index;
        t_word    write_data;
        t_word    pad_levels;
    } t_item;

    typedef struct packed {
        t_word read_data;
        logic  irq;
        t_word drive_enable;
        t_word drive_level;
    } t_result;

endpackage

// ===== rtl/gsc_if.sv =====
// ----------------------------------------------------------------------------
// gsc_if: item and result channels
// Valid/ready channels carrying the bus/pad item and the result item.
// ----------------------------------------------------------------------------
interface gsc_in_if import gsc_pkg::*;;
    logic     valid;
    logic     ready;
    t_opcode  opcode;
    t_reg_idx reg_index;
    t_word    write_data;
    t_word    pad_levels;

    modport source (output valid, opcode, reg_index, write_data, pad_levels, input ready);
    modport sink   (input valid, opcode, reg_index, write_data, pad_levels, output ready);
endinterface

interface gsc_out_if import gsc_pkg::*;;
    logic  valid;
    logic  ready;
    t_word read_data;
    logic  irq;
    t_word drive_enable;
    t_word drive_level;

    modport source (output valid, read_data, irq, drive_enable, drive_level, input ready);
    modport sink   (input valid, read_data, irq, drive_enable, drive_level, output ready);
endinterface

// ===== rtl/gpio_set_clear_register_block.sv =====
// ----------------------------------------------------------------------------
// gpio_set_clear_register_block: 32-pin GPIO controller register block
// Input register, register bank update and result register.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one item per handshake: a bus read, a bus write or a pad
//   level sample (opcode, reg_index, write_data, pad_levels).
//   o_out returns exactly one result per item: read data (zero unless a
//   readable register is read, taken before the item is applied), and the
//   interrupt level and the pin drive enable/level, taken after it is applied.
//   Order: an accepted item waits in the input register; it is applied to
//   the state on the edge that loads its result into the result register.
//   Throughput: one item per cycle while o_out is not held; the state update
//   is a single pass of bitwise logic between the input register and the result register.
//   Stall: while o_out is held the result register keeps its item, the input
//   register holds one more, and i_in.ready drops only when both are full.
//   Reset (i_rst_n low, synchronous): all state words, change flags and the
//   valid flags of both pipeline registers clear; the block is ready right after reset.
//   Bits of write_data and pad_levels at or above PIN_COUNT are ignored.
// ----------------------------------------------------------------------------
module gpio_set_clear_register_block import gsc_pkg::*; #(
    parameter int PIN_COUNT = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    gsc_in_if.sink           i_in,
    gsc_out_if.source        o_out
);

    localparam t_word L_PIN_MASK = 32'((64'd1 << PIN_COUNT) - 64'd1);

    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    logic    advance;
    t_item   bank_item;
    t_result bank_result;

    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in.valid      <= 1'b1;
            r_in.opcode     <= i_in.opcode;
            r_in.reg_index  <= i_in.reg_index;
            r_in.write_data <= i_in.write_data & L_PIN_MASK;
            r_in.pad_levels <= i_in.pad_levels & L_PIN_MASK;
        end
    end

    always_comb begin
        bank_item       = r_in;
        bank_item.valid = advance;
    end

    gsc_regs u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (bank_item),
        .o_result (bank_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= advance || (r_out_valid && !o_out.ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= bank_result;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.read_data    = r_out.read_data;
    assign o_out.irq          = r_out.irq;
    assign o_out.drive_enable = r_out.drive_enable;
    assign o_out.drive_level  = r_out.drive_level;

    a_level_within_enable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> ((o_out.drive_level & ~o_out.drive_enable) == '0))
        else $error("drive level outside drive enable");

    a_pins_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (((o_out.drive_enable | o_out.read_data) & ~L_PIN_MASK) == '0))
        else $error("pin bit above PIN_COUNT set");

    a_accept_fills_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> r_in_valid)
        else $error("accepted item not held in input register");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("applied item produced no result");

endmodule

// ===== rtl/gsc_regs.sv =====
// ----------------------------------------------------------------------------
// gsc_regs: GPIO state words and their update
// Applies one item to the state; read data comes from the state before it, the rest of the result from the new state.
// ----------------------------------------------------------------------------
module gsc_regs import gsc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_item   i_item,
    output t_result o_result
);

    t_word r_owned, n_owned;
    t_word r_oe, n_oe;
    t_word r_filt, n_filt;
    t_word r_odata, n_odata;
    t_word r_pdata, n_pdata;
    t_word r_imask, n_imask;
    t_word r_change, n_change;
    t_word r_odrain, n_odrain;
    t_word r_pullup, n_pullup;
    t_word r_bsel, n_bsel;
    t_word r_owen, n_owen;

    t_word rdata;
    t_word den;
    t_word wd;

    always_comb begin
        n_owned  = r_owned;
        n_oe     = r_oe;
        n_filt   = r_filt;
        n_odata  = r_odata;
        n_pdata  = r_pdata;
        n_imask  = r_imask;
        n_change = r_change;
        n_odrain = r_odrain;
        n_pullup = r_pullup;
        n_bsel   = r_bsel;
        n_owen   = r_owen;
        rdata    = '0;
        wd       = i_item.write_data;

        if (i_item.valid) begin
            case (i_item.opcode)
                OP_READ: begin
                    case (i_item.reg_index)
                        REG_PSR:  rdata = r_owned;
                        REG_OSR:  rdata = r_oe;
                        REG_IFSR: rdata = r_filt;
                        REG_ODSR: rdata = r_odata;
                        REG_PDSR: rdata = r_pdata;
                        REG_IMR:  rdata = r_imask;
                        REG_ISR: begin
                            rdata    = r_change;
                            n_change = '0;
                        end
                        REG_MDSR: rdata = r_odrain;
                        REG_PUSR: rdata = r_pullup;
                        REG_ABSR: rdata = r_bsel;
                        REG_OWSR: rdata = r_owen;
                        default:  rdata = '0;
                    endcase
                end
                OP_WRITE: begin
                    case (i_item.reg_index)
                        REG_PER:  n_owned  = r_owned | wd;
                        REG_PDR:  n_owned  = r_owned & ~wd;
                        REG_OER:  n_oe     = r_oe | wd;
                        REG_ODR:  n_oe     = r_oe & ~wd;
                        REG_IFER: n_filt   = r_filt | wd;
                        REG_IFDR: n_filt   = r_filt & ~wd;
                        REG_SODR: n_odata  = r_odata | wd;
                        REG_CODR: n_odata  = r_odata & ~wd;
                        REG_ODSR: n_odata  = (r_odata & ~r_owen) | (wd & r_owen);
                        REG_IER:  n_imask  = r_imask | wd;
                        REG_IDR:  n_imask  = r_imask & ~wd;
                        REG_MDER: n_odrain = r_odrain | wd;
                        REG_MDDR: n_odrain = r_odrain & ~wd;
                        REG_PUDR: n_pullup = r_pullup & ~wd;
                        REG_PUER: n_pullup = r_pullup | wd;
                        REG_ASR:  n_bsel   = r_bsel & ~wd;
                        REG_BSR:  n_bsel   = r_bsel | wd;
                        REG_OWER: n_owen   = r_owen | wd;
                        REG_OWDR: n_owen   = r_owen & ~wd;
                        default: ;
                    endcase
                end
                OP_SAMPLE: begin
                    n_change = r_change | (r_pdata ^ i_item.pad_levels);
                    n_pdata  = i_item.pad_levels;
                end
                default: ;
            endcase
        end

        // open-drain pins only pull low
        den = n_owned & n_oe & (~n_odrain | ~n_odata);

        o_result.read_data    = rdata;
        o_result.irq          = |(n_change & n_imask);
        o_result.drive_enable = den;
        o_result.drive_level  = n_odata & den;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owned  <= '0;
            r_oe     <= '0;
            r_filt   <= '0;
            r_odata  <= '0;
            r_pdata  <= '0;
            r_imask  <= '0;
            r_change <= '0;
            r_odrain <= '0;
            r_pullup <= '0;
            r_bsel   <= '0;
            r_owen   <= '0;
        end else begin
            r_owned  <= n_owned;
            r_oe     <= n_oe;
            r_filt   <= n_filt;
            r_odata  <= n_odata;
            r_pdata  <= n_pdata;
            r_imask  <= n_imask;
            r_change <= n_change;
            r_odrain <= n_odrain;
            r_pullup <= n_pullup;
            r_bsel   <= n_bsel;
            r_owen   <= n_owen;
        end
    end

endmodule
